>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CSE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Implication checked at every clock edge, reset included.
`define CSE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

>>> hw/rtl/cse_pkg.sv
// Package with types, constants and functions of the CAN signal decoder.
`default_nettype none
package cse_pkg;
    localparam int unsigned DataW = 64;
    localparam int unsigned NumBytes = 8;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        KIND_SIGNED   = 2'd0,
        KIND_UNSIGNED = 2'd1,
        KIND_FLOAT32  = 2'd2,
        KIND_DOUBLE   = 2'd3
    } value_kind_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic [DataW-1:0] raw;
        logic [6:0]       len;
        logic             sign_ext;
        logic             empty;
        value_kind_t      kind;
    } work_t;

    // Reverse the byte order of a 64-bit word.
    function automatic logic [DataW-1:0] reverse_bytes(input logic [DataW-1:0] v);
        logic [DataW-1:0] r;
        r = '0;
        for (int i = 0; i < NumBytes; i++)
        begin
            r[8*(NumBytes-1-i) +: 8] = v[8*i +: 8];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/cse_front.sv
// Front part: masks the payload, locates the signal and extracts the raw field.
`default_nettype none
module cse_front (
    input  wire logic [63:0]         frame_data,
    input  wire logic [3:0]          frame_length,
    input  wire logic [5:0]          start_bit,
    input  wire logic [6:0]          bit_length,
    input  wire logic                motorola_order,
    input  wire logic [1:0]          value_kind,
    output cse_pkg::work_t           work
);
    import cse_pkg::*;

    logic [63:0] data_masked;
    logic [63:0] data_sel;
    logic [63:0] field_mask;
    logic [6:0]  len_sat;
    logic [8:0]  moto_shift;
    logic [8:0]  shift;
    logic [63:0] raw;
    logic [2:0]  bit_in_byte;
    logic [3:0]  tail;

    // Clear bytes past the frame length.
    always_comb
    begin
        data_masked = frame_data;
        for (int i = 0; i < NumBytes; i++)
        begin
            if (frame_length < 4'(i + 1))
            begin
                data_masked[8*i +: 8] = 8'h00;
            end
        end
    end

    // Saturate the length and build the field mask.
    always_comb
    begin
        len_sat = (bit_length > 7'd64) ? 7'd64 : bit_length;
        field_mask = (len_sat == 7'd64) ? '1 : ((64'd1 << len_sat[5:0]) - 64'd1);
    end

    // Convert a Motorola start bit; a negative result wraps out of range.
    always_comb
    begin
        bit_in_byte = 3'(start_bit[2:0] + 3'd1);
        tail = (bit_in_byte == 3'd0) ? 4'd0 : 4'(4'd8 - {1'b0, bit_in_byte});
        moto_shift = 9'd64 - {3'b000, start_bit[5:3], 3'b000} - {5'd0, tail}
            - {2'b00, len_sat};
        shift = motorola_order ? moto_shift : {3'b000, start_bit};
        data_sel = motorola_order ? reverse_bytes(data_masked) : data_masked;
        raw = (shift[8:6] == 3'd0) ? ((data_sel >> shift[5:0]) & field_mask) : '0;
    end

    // Package the request for the back part.
    always_comb
    begin
        work.empty = (frame_length == 4'd0);
        work.raw = work.empty ? '0 : raw;
        work.len = len_sat;
        work.kind = value_kind_t'(value_kind);
        work.sign_ext = 1'b0;
        if (len_sat != 7'd0 && len_sat != 7'd64)
        begin
            work.sign_ext = raw[len_sat[5:0] - 6'd1];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/cse_queue.sv
// Short request queue between the front and back parts.
`default_nettype none
module cse_queue #(
    parameter int unsigned Depth = cse_pkg::QueueDepth
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  cse_pkg::work_t in_work,
    output logic          out_valid,
    input  wire logic     out_ready,
    output cse_pkg::work_t out_work
);
    import cse_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    work_t           mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready = (count_reg != (PtrW+1)'(Depth));
    assign out_valid = (count_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_work = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_work;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/cse_back.sv
// Back part: turns the raw field into a double and holds the result register.
`default_nettype none
module cse_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  cse_pkg::work_t  in_work,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [63:0]     value_bits,
    output logic [63:0]     raw_field,
    output logic            frame_empty
);
    import cse_pkg::*;

    logic        valid_reg;
    logic [63:0] value_reg, value_next;
    logic [63:0] raw_reg;
    logic        empty_reg;

    logic        neg;
    logic [63:0] fill;
    logic [63:0] mag;
    logic [5:0]  lz;
    logic        found;
    logic [63:0] norm;
    logic [52:0] mant;
    logic        round_up;
    logic [53:0] mant_r;
    logic [10:0] expo;
    logic [63:0] int_bits;

    logic [7:0]  f_ex;
    logic [22:0] f_man;
    logic [4:0]  f_lz;
    logic        f_found;
    logic [22:0] f_norm;
    logic [63:0] flt_bits;

    assign in_ready = !valid_reg || out_ready;

    // Integer to double with round to nearest, ties to even.
    always_comb
    begin
        neg = (in_work.kind == KIND_SIGNED) && (in_work.sign_ext || in_work.raw[63]);
        // Bits above the field, set when a narrow signed field is negative.
        fill = (in_work.len == 7'd64) ? '0 : ~((64'd1 << in_work.len[5:0]) - 64'd1);
        if (in_work.kind == KIND_SIGNED && in_work.sign_ext)
        begin
            mag = (~(in_work.raw | fill)) + 64'd1;
        end
        else if (neg)
        begin
            mag = (~in_work.raw) + 64'd1;
        end
        else
        begin
            mag = in_work.raw;
        end
        lz = '0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                found = 1'b1;
                lz = 6'(63 - i);
            end
        end
        norm = mag << lz;
        mant = norm[63:11];
        round_up = norm[10] && (norm[9:0] != '0 || norm[11]);
        mant_r = {1'b0, mant} + 54'(round_up);
        expo = 11'(1023 + 63) - {5'd0, lz} + 11'(mant_r[53]);
        if (!found)
        begin
            int_bits = {neg, 63'd0};
        end
        else
        begin
            int_bits = {neg, expo, mant_r[53] ? mant_r[52:1] : mant_r[51:0]};
        end
    end

    // Float32 widening, with subnormal normalization and quieted NaN.
    always_comb
    begin
        f_ex = in_work.raw[30:23];
        f_man = in_work.raw[22:0];
        f_lz = '0;
        f_found = 1'b0;
        for (int i = 22; i >= 0; i--)
        begin
            if (!f_found && f_man[i])
            begin
                f_found = 1'b1;
                f_lz = 5'(22 - i);
            end
        end
        f_norm = f_man << (f_lz + 5'd1);
        if (f_ex == 8'hFF)
        begin
            flt_bits = {in_work.raw[31], 11'h7FF, (f_man != '0) | f_man[22],
                        f_man[21:0], 29'd0};
        end
        else if (f_ex == 8'h00)
        begin
            if (f_man == '0)
            begin
                flt_bits = {in_work.raw[31], 63'd0};
            end
            else
            begin
                flt_bits = {in_work.raw[31], 11'(1023 - 127) - {6'd0, f_lz},
                            f_norm, 29'd0};
            end
        end
        else
        begin
            flt_bits = {in_work.raw[31], {3'd0, f_ex} + 11'(1023 - 127),
                        f_man, 29'd0};
        end
    end

    // Select the value by its kind; an empty frame gives zero.
    always_comb
    begin
        unique case (in_work.kind)
            KIND_SIGNED, KIND_UNSIGNED: value_next = int_bits;
            KIND_FLOAT32:               value_next = flt_bits;
            default:                    value_next = in_work.raw;
        endcase
        if (in_work.empty)
        begin
            value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_reg <= value_next;
            raw_reg <= in_work.raw;
            empty_reg <= in_work.empty;
        end
    end

    assign out_valid = valid_reg;
    assign value_bits = value_reg;
    assign raw_field = raw_reg;
    assign frame_empty = empty_reg;
endmodule
`default_nettype wire

>>> hw/rtl/can_signal_extract_to_double_top.sv
// Top level of the CAN signal decoder.
//   channel | direction | tdata fields (low bit up)                      | tuser
//   s_axis  | in        | frame_data, frame_length, start_bit, bit_length, | -
//           |           | motorola_order, value_kind                       |
//   m_axis  | out       | value_bits, raw_field                            | frame_empty
// One request per cycle while the output is not stalled; a request passes
// through the queue storage and then the result register in the back part.
// Reset clears the queue fill count and the result valid flag.
// A stall at the output fills the two-entry queue before s_axis_tready falls.
`default_nettype none
module can_signal_extract_to_double_top #(
    parameter int unsigned QueueDepth = cse_pkg::QueueDepth
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // frame_data[63:0], frame_length[67:64], start_bit[73:68],
    // bit_length[80:74], motorola_order[81], value_kind[83:82], zero fill.
    input  wire logic [87:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // value_bits[63:0], raw_field[127:64].
    output logic [127:0]      m_axis_tdata,
    // frame_empty[0].
    output logic              m_axis_tuser
);
    import cse_pkg::*;

    work_t       front_work;
    work_t       q_work;
    logic        q_valid, q_ready;
    logic [63:0] value_bits, raw_field;

    cse_front u_front (
        .frame_data     (s_axis_tdata[63:0]),
        .frame_length   (s_axis_tdata[67:64]),
        .start_bit      (s_axis_tdata[73:68]),
        .bit_length     (s_axis_tdata[80:74]),
        .motorola_order (s_axis_tdata[81]),
        .value_kind     (s_axis_tdata[83:82]),
        .work           (front_work)
    );

    cse_queue #(.Depth(QueueDepth)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_work   (front_work),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_work  (q_work)
    );

    cse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_work     (q_work),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .value_bits  (value_bits),
        .raw_field   (raw_field),
        .frame_empty (m_axis_tuser)
    );

    assign m_axis_tdata = {raw_field, value_bits};
endmodule
`default_nettype wire

>>> hw/rtl/cse_checker.sv
// Port-level checker for the CAN signal decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cse_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);
    // A waiting result holds still.
    `CSE_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    // An empty frame carries zero value and raw field.
    `CSE_ASSERT(a_empty_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    // Once reset has been seen at an edge, no result is shown at the next one.
    `CSE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !m_axis_tvalid)
    // An accepted request with a free output leads to a result after the queue and result registers.
    `CSE_ASSERT(a_latency, clk, rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid ##1 m_axis_tready |=> m_axis_tvalid)
endmodule

bind can_signal_extract_to_double_top cse_checker u_cse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
